FILE: src/aes128_cbc_block_cipher_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the AES-128 CBC block
// Shared concurrent property wrappers used by the RTL.
// ---------------------------------------------------------------------------
`ifndef AES128_CBC_BLOCK_CIPHER_TOP_MACROS_SVH
`define AES128_CBC_BLOCK_CIPHER_TOP_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: src/aes_pkg.sv
// ---------------------------------------------------------------------------
// AES package
// Types, constants and round functions shared by the AES-128 CBC block.
// ---------------------------------------------------------------------------
package aes_pkg;
   localparam int NB = 4;
   localparam int KEY_ROUNDS = 10;
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;
   localparam logic [3:0] REG_KEY_HIGH = 4'd0;
   localparam logic [3:0] REG_KEY_LOW  = 4'd1;
   localparam logic [3:0] REG_IV_HIGH  = 4'd2;
   localparam logic [3:0] REG_IV_LOW   = 4'd3;

   typedef struct packed {
      logic load;       // accept a block: xor/keyadd into state, reset key
      logic decrypt;    // direction of this block
      logic restart;    // take IV as chain
      logic round;      // run one round
      logic last;       // this round is the final one
      logic finish;     // capture result and update chain
   } dp_cmd_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[x];
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction
endpackage

FILE: src/aes_ctrl.sv
// ---------------------------------------------------------------------------
// AES controller
// Sequences accept, ROUNDS rounds (ten by default) and result hand-off for one block.
// ---------------------------------------------------------------------------
`include "aes128_cbc_block_cipher_top_macros.svh"
module aes_ctrl #(
   parameter int ROUNDS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_command,
   input  logic                 req_restart_chain,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 key_busy,
   output aes_pkg::dp_cmd_type  cmd
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int CW = $clog2(ROUNDS + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] round_ff, round_in;
   logic dec_ff, dec_in;

   // result slot is free once the waiting beat leaves; hold off while the
   // decryption key is being rebuilt
   assign req_ready = !key_busy &&
                      ((state_ff == ST_IDLE) || (state_ff == ST_DONE && rsp_ready));
   assign rsp_valid = (state_ff == ST_DONE);

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      dec_in   = dec_ff;
      cmd      = '0;
      cmd.decrypt = dec_ff;
      case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (req_valid && req_ready) begin
               cmd.load    = 1'b1;
               cmd.decrypt = req_command;
               cmd.restart = req_restart_chain;
               dec_in      = req_command;
               round_in    = CW'(1);
               state_in    = ST_RUN;
            end else if (state_ff == ST_DONE && rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            cmd.round = 1'b1;
            cmd.last  = (round_ff == CW'(ROUNDS));
            round_in  = round_ff + CW'(1);
            if (cmd.last) begin
               cmd.finish = 1'b1;
               state_in   = ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         dec_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         dec_ff   <= dec_in;
      end
   end

   `ASSERT_IMPL(a_no_accept_in_run, clock, reset, state_ff == ST_RUN, !req_ready)
   `ASSERT_NEXT(a_last_to_done, clock, reset, cmd.finish, rsp_valid)
   `ASSERT_IMPL(a_round_range, clock, reset, state_ff == ST_RUN,
      round_ff != '0 && round_ff <= CW'(ROUNDS))
endmodule

FILE: src/aes_datapath.sv
// ---------------------------------------------------------------------------
// AES datapath
// State register, on-the-fly key schedule, decryption key builder and CBC
// chain.
// ---------------------------------------------------------------------------
module aes_datapath #(
   parameter int ROUNDS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  aes_pkg::dp_cmd_type cmd,
   input  logic [127:0]        key,
   input  logic [127:0]        iv,
   input  logic [127:0]        blk,
   input  logic                key_start,
   output logic                key_busy,
   output logic [127:0]        result
);
   localparam int KW = $clog2(ROUNDS + 2);

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] blkin_ff, blkin_in;
   logic [127:0] res_ff, res_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [127:0] kx_ff, kx_in;
   logic [7:0]   kx_rc_ff, kx_rc_in;
   logic [KW-1:0] kx_cnt_ff, kx_cnt_in;
   logic [127:0] fwd_key, bwd_key, nkey;
   logic [127:0] prev, sb, sr, mc, rnd, fin;
   logic [7:0]   b [16];
   logic [7:0]   t [16];

   // key step forward: w[i] = w[i-4] ^ f(w[i-1])
   function automatic logic [127:0] kstep(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3;
      w0 = k[127:96] ^ aes_pkg::sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      w3 = k[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // inverse step: recover previous round key from k
   function automatic logic [127:0] kback(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] p0, p1, p2, p3;
      p3 = k[31:0] ^ k[63:32];
      p2 = k[63:32] ^ k[95:64];
      p1 = k[95:64] ^ k[127:96];
      p0 = k[127:96] ^ aes_pkg::sub_word({p3[23:0], p3[31:24]}) ^ {rc, 24'h0};
      return {p0, p1, p2, p3};
   endfunction

   function automatic logic [7:0] xinv(input logic [7:0] a);
      return a[0] ? ({1'b0, a[7:1]} ^ 8'h8d) : {1'b0, a[7:1]};
   endfunction

   function automatic logic [127:0] mix(input logic [127:0] s, input logic inv);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3, u, v;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         if (inv) begin
            // pre-condition then forward mix
            u = aes_pkg::xt(aes_pkg::xt(a0 ^ a2));
            v = aes_pkg::xt(aes_pkg::xt(a1 ^ a3));
            a0 = a0 ^ u; a1 = a1 ^ v; a2 = a2 ^ u; a3 = a3 ^ v;
         end
         u = a0 ^ a1 ^ a2 ^ a3;
         o[127-32*c -: 8] = a0 ^ u ^ aes_pkg::xt(a0 ^ a1);
         o[119-32*c -: 8] = a1 ^ u ^ aes_pkg::xt(a1 ^ a2);
         o[111-32*c -: 8] = a2 ^ u ^ aes_pkg::xt(a2 ^ a3);
         o[103-32*c -: 8] = a3 ^ u ^ aes_pkg::xt(a3 ^ a0);
      end
      return o;
   endfunction

   // last round key for decryption: load the key, then one schedule step per
   // cycle; afterwards kx_rc_ff is the constant one past the final round
   always_comb begin
      kx_in     = kx_ff;
      kx_rc_in  = kx_rc_ff;
      kx_cnt_in = kx_cnt_ff;
      if (key_start) begin
         kx_cnt_in = KW'(ROUNDS + 1);
      end else if (kx_cnt_ff == KW'(ROUNDS + 1)) begin
         kx_in     = key;
         kx_rc_in  = 8'h01;
         kx_cnt_in = KW'(ROUNDS);
      end else if (kx_cnt_ff != '0) begin
         kx_in     = kstep(kx_ff, kx_rc_ff);
         kx_rc_in  = aes_pkg::xt(kx_rc_ff);
         kx_cnt_in = kx_cnt_ff - KW'(1);
      end
   end

   assign key_busy = (kx_cnt_ff != '0);

   assign prev = cmd.restart ? iv : chain_ff;

   always_comb begin
      for (int i = 0; i < 16; i++) b[i] = state_ff[127-8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            if (cmd.decrypt) t[r + 4*((c + r) & 3)] = b[r + 4*c];
            else t[r + 4*c] = b[r + 4*((c + r) & 3)];
         end
      for (int i = 0; i < 16; i++) begin
         sb[127-8*i -: 8] = cmd.decrypt ? aes_pkg::inv_sbox(t[i]) : aes_pkg::sbox(t[i]);
      end
      sr = sb;
      fwd_key = kstep(rkey_ff, rcon_ff);
      bwd_key = kback(rkey_ff, rcon_ff);
      nkey = cmd.decrypt ? bwd_key : fwd_key;
      if (cmd.last) mc = sr;
      else if (cmd.decrypt) mc = mix(sr ^ nkey, 1'b1);
      else mc = mix(sr, 1'b0);
      rnd = (cmd.decrypt && !cmd.last) ? mc : (mc ^ nkey);
      fin = cmd.decrypt ? (rnd ^ chain_ff) : rnd;
   end

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      chain_in = chain_ff;
      blkin_in = blkin_ff;
      res_in   = res_ff;
      if (cmd.load) begin
         blkin_in = blk;
         chain_in = prev;
         if (cmd.decrypt) begin
            state_in = blk ^ kx_ff;
            rkey_in  = kx_ff;
            rcon_in  = xinv(kx_rc_ff);
         end else begin
            state_in = blk ^ prev ^ key;
            rkey_in  = key;
            rcon_in  = 8'h01;
         end
      end else if (cmd.round) begin
         state_in = rnd;
         rkey_in  = nkey;
         rcon_in  = cmd.decrypt ? xinv(rcon_ff) : aes_pkg::xt(rcon_ff);
         if (cmd.finish) begin
            res_in   = fin;
            chain_in = cmd.decrypt ? blkin_ff : rnd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff  <= '0;
         kx_cnt_ff <= KW'(ROUNDS + 1);
      end else begin
         chain_ff  <= chain_in;
         kx_cnt_ff <= kx_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      blkin_ff <= blkin_in;
      res_ff   <= res_in;
      kx_ff    <= kx_in;
      kx_rc_ff <= kx_rc_in;
   end

   assign result = res_ff;
endmodule

FILE: src/aes128_cbc_block_cipher_top.sv
// ---------------------------------------------------------------------------
// AES-128 CBC block cipher
// Top level: APB register file, controller and round datapath.
// ---------------------------------------------------------------------------
// One beat on req_ carries a 128-bit block, a direction and a chain restart
// flag; one beat on rsp_ returns the processed block. After acceptance the
// block first has the first round key (and the chain value on encryption)
// added, then runs one AES round per cycle through the shared round unit. The
// next block can be taken in the same cycle that the previous result leaves,
// so a new block is not accepted until the previous one is through, a limit
// set by the serial round loop that CBC chaining imposes. Round keys are
// worked out alongside the rounds; decryption starts from the last round key,
// which a small sequencer rebuilds one schedule step per cycle after reset and
// after every key write, holding req_ready low meanwhile. Key and IV registers
// sit at byte addresses 0, 8, 16 and 24 of a 64-bit APB port.
module aes128_cbc_block_cipher_top #(
   parameter int ROUNDS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic        req_restart_chain,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   logic [63:0] key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic        wr;
   logic [3:0]  idx;
   logic        key_start;
   logic        key_busy;
   aes_pkg::dp_cmd_type cmd;
   logic [127:0] result;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = {1'b0, csr_paddr[4:3]};

   // a key write restarts the decryption key builder
   assign key_start = wr && (csr_paddr[2:0] == 3'd0) &&
                      (idx == aes_pkg::REG_KEY_HIGH || idx == aes_pkg::REG_KEY_LOW);

   // hold register values; the user must make writes only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (wr && csr_paddr[2:0] == 3'd0) begin
         case (idx)
            aes_pkg::REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            aes_pkg::REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            aes_pkg::REG_IV_HIGH:  iv_high_ff  <= csr_pwdata;
            aes_pkg::REG_IV_LOW:   iv_low_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         aes_pkg::REG_KEY_HIGH: csr_prdata = key_high_ff;
         aes_pkg::REG_KEY_LOW:  csr_prdata = key_low_ff;
         aes_pkg::REG_IV_HIGH:  csr_prdata = iv_high_ff;
         aes_pkg::REG_IV_LOW:   csr_prdata = iv_low_ff;
         default:               csr_prdata = '0;
      endcase
   end

   aes_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_command, .req_restart_chain,
      .rsp_valid, .rsp_ready, .key_busy, .cmd
   );

   aes_datapath #(.ROUNDS(ROUNDS)) u_dp (
      .clock, .reset, .cmd,
      .key({key_high_ff, key_low_ff}),
      .iv({iv_high_ff, iv_low_ff}),
      .blk({req_block_high, req_block_low}),
      .key_start,
      .key_busy,
      .result
   );

   assign rsp_result_high = result[127:64];
   assign rsp_result_low  = result[63:0];
endmodule
